// ----- src/hwgemv_pkg.sv -----
// shared types, constants and float helper functions for the half-weight gemv unit
package hwgemv_pkg;

  localparam int CNT_W  = 17;  // wide enough for a row length up to 65536
  localparam int RLEN_W = 13;  // row_length register width
  localparam int CFG_W  = 13;  // config write data width
  localparam int EXP_W  = 12;  // internal signed exponent width

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] ONE_F32   = 32'h3F80_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_USE_BIAS   = 1'b1;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_NORM_A,
    ST_ALIGN,
    ST_ADD,
    ST_NORM_B,
    ST_ROUND,
    ST_PACK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       capture;
    logic       mul;
    logic       norm;
    logic [1:0] norm_step;
    logic       align;
    logic       add;
    logic       round;
    logic       pack;
    logic       bias_pass;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic spec;
    logic last;
    logic use_bias;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [23:0]             sig;
    logic signed [EXP_W-1:0] ex;
  } fp_dec_t;

  typedef struct packed {
    logic [60:0]             m;
    logic signed [EXP_W-1:0] e;
  } norm_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return x[30:0] == INF_MAG;
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // exact binary16 to binary32, subnormal halves come out normal
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] pos;
    logic [9:0] mn;
    logic [7:0] ex;
    logic [31:0] r;
    s   = h[15];
    e   = h[14:10];
    m   = h[9:0];
    pos = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) pos = 4'(i);
    end
    if (e == 5'd0) begin
      if (m == 10'd0) begin
        r = {s, 31'd0};
      end else begin
        ex = 8'd103 + 8'(pos);
        mn = m << (4'd10 - pos);
        r  = {s, ex, mn, 13'd0};
      end
    end else if (e == 5'h1F) begin
      r = {s, 8'hFF, m, 13'd0};
    end else begin
      r = {s, 8'(e) + 8'd112, m, 13'd0};
    end
    return r;
  endfunction

  // value = sig * 2^ex
  function automatic fp_dec_t decode(input logic [31:0] x);
    fp_dec_t d;
    if (x[30:23] == 8'd0) begin
      d.sig = {1'b0, x[22:0]};
      d.ex  = -12'sd149;
    end else begin
      d.sig = {1'b1, x[22:0]};
      d.ex  = $signed({4'd0, x[30:23]}) - 12'sd150;
    end
    return d;
  endfunction

endpackage

// ----- src/hwgemv_if.sv -----
// request and result channels of the half-weight gemv unit
interface hwgemv_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] act_index;
  logic [31:0] activation;
  logic [15:0] weight;
  logic [31:0] bias;

  modport source (output valid, mode, act_index, activation, weight, bias, input ready);
  modport sink (input valid, mode, act_index, activation, weight, bias, output ready);
endinterface

interface hwgemv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_sum;
  logic [15:0] row_index;

  modport source (output valid, row_sum, row_index, input ready);
  modport sink (input valid, row_sum, row_index, output ready);
endinterface

// ----- src/hwgemv_ctrl.sv -----
// sequencing state machine of the half-weight gemv unit
module hwgemv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mode,
  output logic               in_ready,
  input  hwgemv_pkg::status_t sts,
  output hwgemv_pkg::cmd_t    cmd
);

  hwgemv_pkg::state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hwgemv_pkg::ST_IDLE;
      step_r  <= 2'd0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    cmd           = '0;
    cmd.norm_step = step_r;
    cmd.bias_pass = pass_r;
    in_ready      = 1'b0;
    unique case (state_r)
      hwgemv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == hwgemv_pkg::MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            pass_nxt    = 1'b0;
            state_nxt   = hwgemv_pkg::ST_READ;
          end
        end
      end
      hwgemv_pkg::ST_READ: state_nxt = hwgemv_pkg::ST_MUL;
      hwgemv_pkg::ST_MUL: begin
        cmd.mul  = 1'b1;
        step_nxt = 2'd0;
        state_nxt = sts.spec ? hwgemv_pkg::ST_PACK : hwgemv_pkg::ST_NORM_A;
      end
      hwgemv_pkg::ST_NORM_A: begin
        cmd.norm = 1'b1;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) state_nxt = hwgemv_pkg::ST_ALIGN;
      end
      hwgemv_pkg::ST_ALIGN: begin
        cmd.align = 1'b1;
        state_nxt = hwgemv_pkg::ST_ADD;
      end
      hwgemv_pkg::ST_ADD: begin
        cmd.add   = 1'b1;
        step_nxt  = 2'd0;
        state_nxt = hwgemv_pkg::ST_NORM_B;
      end
      hwgemv_pkg::ST_NORM_B: begin
        cmd.norm = 1'b1;
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd2) state_nxt = hwgemv_pkg::ST_ROUND;
      end
      hwgemv_pkg::ST_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = hwgemv_pkg::ST_PACK;
      end
      hwgemv_pkg::ST_PACK: begin
        cmd.pack = 1'b1;
        if (pass_r) begin
          state_nxt = hwgemv_pkg::ST_EMIT;
        end else if (sts.last) begin
          if (sts.use_bias) begin
            // second pass through the fma: 1.0 * bias + row sum
            pass_nxt  = 1'b1;
            state_nxt = hwgemv_pkg::ST_MUL;
          end else begin
            state_nxt = hwgemv_pkg::ST_EMIT;
          end
        end else begin
          state_nxt = hwgemv_pkg::ST_IDLE;
        end
      end
      hwgemv_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = hwgemv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hwgemv_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/hwgemv_dp.sv -----
// datapath: activation memory, counters, multi-cycle fp32 fma and result register
module hwgemv_dp #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int MAX_ROWS       = 65536
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [hwgemv_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic [11:0]                   in_act_index,
  input  logic [31:0]                   in_activation,
  input  logic [15:0]                   in_weight,
  input  logic [31:0]                   in_bias,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_row_sum,
  output logic [15:0]                   out_row_index,
  input  hwgemv_pkg::cmd_t              cmd,
  output hwgemv_pkg::status_t           sts
);

  localparam int AW = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = hwgemv_pkg::CNT_W;
  localparam int EW = hwgemv_pkg::EXP_W;
  localparam logic [CW-1:0] MAX_LEN  = CW'(MAX_ROW_LENGTH);
  localparam logic [RW-1:0] LAST_ROW = RW'(MAX_ROWS - 1);

  logic [hwgemv_pkg::RLEN_W-1:0] row_length_r;
  logic        use_bias_r;
  logic [31:0] mem [MAX_ROW_LENGTH];
  logic [31:0] mem_q;
  logic [15:0] weight_r;
  logic [31:0] bias_r;
  logic [31:0] acc_r;
  logic [AW-1:0] elem_r;
  logic [RW-1:0] row_r;
  logic        out_valid_r;
  logic [31:0] out_sum_r;
  logic [15:0] out_row_r;

  logic [60:0]          mp_r, mc_r;
  logic signed [EW-1:0] ep_r, ec_r, eq_r;
  logic                 ps_r, cs_r, czero_r, sub_r, zres_r, spec_r;
  logic [5:0]           dsh_r;
  logic [31:0]          spec_val_r;
  logic [24:0]          q_r;

  // row length clamp and end of row
  logic [CW-1:0] rl_ext, len;
  logic          last;
  always_comb begin
    rl_ext = CW'(row_length_r);
    if (rl_ext == '0) len = CW'(1);
    else if (rl_ext > MAX_LEN) len = MAX_LEN;
    else len = rl_ext;
    last = (CW'(elem_r) + CW'(1)) >= len;
  end

  // operands and special values
  logic [31:0] a_bits, b_bits, c_bits;
  logic        ps, cs, spec;
  logic [31:0] spec_val;
  logic [47:0] prod;
  hwgemv_pkg::fp_dec_t da, db, dc;
  always_comb begin
    a_bits = cmd.bias_pass ? hwgemv_pkg::ONE_F32 : hwgemv_pkg::widen_half(weight_r);
    b_bits = cmd.bias_pass ? bias_r : mem_q;
    c_bits = acc_r;
    da = hwgemv_pkg::decode(a_bits);
    db = hwgemv_pkg::decode(b_bits);
    dc = hwgemv_pkg::decode(c_bits);
    prod = da.sig * db.sig;
    ps = a_bits[31] ^ b_bits[31];
    cs = c_bits[31];
    spec = 1'b1;
    spec_val = hwgemv_pkg::CANON_NAN;
    if (hwgemv_pkg::is_nan(a_bits) || hwgemv_pkg::is_nan(b_bits) ||
        hwgemv_pkg::is_nan(c_bits)) begin
      spec_val = hwgemv_pkg::CANON_NAN;
    end else if (hwgemv_pkg::is_inf(a_bits) || hwgemv_pkg::is_inf(b_bits)) begin
      if (hwgemv_pkg::is_zero(a_bits) || hwgemv_pkg::is_zero(b_bits) ||
          (hwgemv_pkg::is_inf(c_bits) && (cs != ps)))
        spec_val = hwgemv_pkg::CANON_NAN;
      else
        spec_val = {ps, hwgemv_pkg::INF_MAG};
    end else if (hwgemv_pkg::is_inf(c_bits)) begin
      spec_val = c_bits;
    end else if (hwgemv_pkg::is_zero(a_bits) || hwgemv_pkg::is_zero(b_bits)) begin
      if (hwgemv_pkg::is_zero(c_bits)) spec_val = (ps == cs) ? c_bits : 32'd0;
      else spec_val = c_bits;
    end else begin
      spec = 1'b0;
    end
  end

  // two conditional left shifts toward bit 60
  function automatic hwgemv_pkg::norm_t norm_step(input logic [60:0] m,
                                                  input logic signed [EW-1:0] e,
                                                  input logic [1:0] step);
    hwgemv_pkg::norm_t r;
    int w1;
    int w2;
    case (step)
      2'd0:    begin w1 = 32; w2 = 16; end
      2'd1:    begin w1 = 8;  w2 = 4;  end
      default: begin w1 = 2;  w2 = 1;  end
    endcase
    r.m = m;
    r.e = e;
    if ((r.m >> (61 - w1)) == '0) begin
      r.m = r.m << w1;
      r.e = r.e - EW'(w1);
    end
    if ((r.m >> (61 - w2)) == '0) begin
      r.m = r.m << w2;
      r.e = r.e - EW'(w2);
    end
    return r;
  endfunction

  hwgemv_pkg::norm_t np, nc;
  always_comb begin
    np = norm_step(mp_r, ep_r, cmd.norm_step);
    nc = norm_step(mc_r, ec_r, cmd.norm_step);
  end

  // alignment: larger magnitude goes to the big operand
  logic                 pbig;
  logic signed [EW-1:0] dexp;
  logic [5:0]           dclamp;
  always_comb begin
    pbig = czero_r || (ep_r > ec_r) || ((ep_r == ec_r) && (mp_r >= mc_r));
    dexp = pbig ? (ep_r - ec_r) : (ec_r - ep_r);
    if (czero_r) dclamp = 6'd0;
    else if (dexp >= EW'(63)) dclamp = 6'd63;
    else dclamp = dexp[5:0];
  end

  // add or subtract with sticky
  logic [60:0] small_sh;
  logic [61:0] sum;
  always_comb begin
    if (dsh_r == 6'd63) small_sh = 61'd1;
    else small_sh = (mc_r >> dsh_r) |
                    61'(|(mc_r & ((61'd1 << dsh_r) - 61'd1)));
    sum = sub_r ? ({1'b0, mp_r} - {1'b0, small_sh}) : ({1'b0, mp_r} + {1'b0, small_sh});
  end

  // round to nearest even, subnormal aware
  logic signed [EW-1:0] tsub;
  logic [5:0]           sh;
  logic [24:0]          q;
  logic                 guard, rest;
  logic [61:0]          mp_x;
  always_comb begin
    tsub = -EW'(149) - ep_r;
    if (tsub > EW'(62)) sh = 6'd62;
    else if (tsub > EW'(37)) sh = tsub[5:0];
    else sh = 6'd37;
    // one zero bit on top so a shift of 62 finds a clear guard bit
    mp_x  = {1'b0, mp_r};
    q     = 25'(mp_r >> sh);
    guard = mp_x[sh - 6'd1];
    rest  = |(mp_x & ((62'd1 << (sh - 6'd1)) - 62'd1));
  end

  // pack rounded value
  logic [24:0]          qq;
  logic signed [EW-1:0] ee, biased;
  logic [31:0]          rounded, result;
  always_comb begin
    qq = q_r;
    ee = eq_r;
    if (q_r[24]) begin
      qq = q_r >> 1;
      ee = eq_r + EW'(1);
    end
    biased = ee + EW'(150);
    if (q_r == 25'd0) rounded = {ps_r, 31'd0};
    else if (qq[23]) begin
      if (biased >= EW'(255)) rounded = {ps_r, hwgemv_pkg::INF_MAG};
      else rounded = {ps_r, biased[7:0], qq[22:0]};
    end else rounded = {ps_r, 8'd0, qq[22:0]};
    if (spec_r) result = spec_val_r;
    else if (zres_r) result = 32'd0;
    else result = rounded;
  end

  // activation memory
  always_ff @(posedge clk) begin
    if (cmd.load && (CW'(in_act_index) < MAX_LEN))
      mem[AW'(in_act_index)] <= in_activation;
    mem_q <= mem[elem_r];
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= hwgemv_pkg::RLEN_W'(4096);
      use_bias_r   <= 1'b0;
      acc_r        <= 32'd0;
      elem_r       <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hwgemv_pkg::REG_ROW_LENGTH: row_length_r <= cfg_wdata;
          hwgemv_pkg::REG_USE_BIAS:   use_bias_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        acc_r  <= 32'd0;
        elem_r <= '0;
        row_r  <= '0;
      end
      if (cmd.pack) begin
        acc_r <= result;
        if (!cmd.bias_pass) elem_r <= last ? '0 : elem_r + AW'(1);
      end
      if (cmd.emit) begin
        acc_r       <= 32'd0;
        row_r       <= (row_r == LAST_ROW) ? '0 : row_r + RW'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      weight_r <= in_weight;
      bias_r   <= in_bias;
    end
    if (cmd.emit) begin
      out_sum_r <= hwgemv_pkg::is_nan(acc_r) ? hwgemv_pkg::CANON_NAN : acc_r;
      out_row_r <= 16'(row_r);
    end
    if (cmd.mul) begin
      mp_r       <= 61'(prod);
      ep_r       <= da.ex + db.ex;
      mc_r       <= 61'(dc.sig);
      ec_r       <= dc.ex;
      ps_r       <= ps;
      cs_r       <= cs;
      czero_r    <= hwgemv_pkg::is_zero(c_bits);
      spec_r     <= spec;
      spec_val_r <= spec_val;
      zres_r     <= 1'b0;
    end
    if (cmd.norm) begin
      mp_r <= np.m;
      ep_r <= np.e;
      mc_r <= nc.m;
      ec_r <= nc.e;
    end
    if (cmd.align) begin
      mp_r  <= pbig ? mp_r : mc_r;
      mc_r  <= czero_r ? 61'd0 : (pbig ? mc_r : mp_r);
      ep_r  <= pbig ? ep_r : ec_r;
      ps_r  <= pbig ? ps_r : cs_r;
      dsh_r <= dclamp;
      sub_r <= (ps_r != cs_r) && !czero_r;
    end
    if (cmd.add) begin
      zres_r <= sub_r && (sum == 62'd0);
      if (sum[61]) begin
        mp_r <= sum[61:1] | 61'(sum[0]);
        ep_r <= ep_r + EW'(1);
      end else begin
        mp_r <= sum[60:0];
      end
    end
    if (cmd.round) begin
      q_r  <= q + 25'(guard & (rest | q[0]));
      eq_r <= ep_r + EW'(sh);
    end
  end

  assign sts.spec     = spec;
  assign sts.last     = last;
  assign sts.use_bias = use_bias_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_row_sum   = out_sum_r;
  assign out_row_index = out_row_r;

endmodule

// ----- src/half_weight_float_gemv_unit.sv -----
// Matrix-vector unit: fp16 weights times fp32 activations, fp32 row sums.
// Activation loads stay in the idle state and can follow one another. A
// weight, once accepted, passes memory read, 24x24 multiply, three normalize
// steps, align, add, three normalize steps, round and pack before the next
// ready, all on the single fp32 fma whose accumulator carries from one weight
// to the next; one whose operands are zero, infinite or NaN goes from the
// multiply straight to pack. The last weight of a row then moves the sum into
// the output register in an emit state, after a bias add pass when use_bias
// is set (straight to pack when an operand of it is zero, infinite or NaN),
// and it waits there while the previous row sum is still held. The output
// register lets the next item in while a row sum waits.
module half_weight_float_gemv_unit #(
  parameter int MAX_ROW_LENGTH = 4096,
  parameter int MAX_ROWS       = 65536
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [hwgemv_pkg::CFG_W-1:0] cfg_wdata,
  hwgemv_in_if.sink                    in_ch,
  hwgemv_out_if.source                 out_ch
);

  hwgemv_pkg::cmd_t    cmd;
  hwgemv_pkg::status_t sts;

  hwgemv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hwgemv_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_ROWS       (MAX_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_act_index  (in_ch.act_index),
    .in_activation (in_ch.activation),
    .in_weight     (in_ch.weight),
    .in_bias       (in_ch.bias),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_row_sum   (out_ch.row_sum),
    .out_row_index (out_ch.row_index),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ----- src/hwgemv_checker.sv -----
// port-level checks for the half-weight gemv unit, bound to the top level
module hwgemv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_row_sum,
  input logic [15:0] out_row_index
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("row sum dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_row_sum) && $stable(out_row_index))
    else $error("row sum changed while stalled");

  // a weight request keeps the unit busy for its fma
  a_weight_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("weight request accepted back to back");

  // activation loads never produce a row sum
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode && !out_valid |=> !out_valid)
    else $error("row sum appeared after an activation load");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("row sum valid right after reset");

endmodule

bind half_weight_float_gemv_unit hwgemv_checker u_hwgemv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_mode       (in_ch.mode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row_sum   (out_ch.row_sum),
  .out_row_index (out_ch.row_index)
);
